// File: hdl/lcdt_pkg.sv
`default_nettype none

package lcdt_pkg;

    typedef enum logic [1:0] {
        MODE_HBLANK = 2'd0,
        MODE_VBLANK = 2'd1,
        MODE_SCAN   = 2'd2,
        MODE_XFER   = 2'd3
    } mode_t;

    // Configuration register indexes.
    localparam logic [1:0] REG_LCD_ENABLE   = 2'd0;
    localparam logic [1:0] REG_STAT_ENABLES = 2'd1;
    localparam logic [1:0] REG_LINE_COMPARE = 2'd2;

    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 8;

    localparam logic [7:0] QUIRK_LINE  = 8'd153;
    localparam logic [8:0] QUIRK_DOT   = 9'd4;
    localparam logic [7:0] OAM_ENTRIES = 8'd40;

    typedef struct packed {
        mode_t       mode;
        logic [8:0]  line_dots;
        logic [16:0] frame_dots;
        logic [7:0]  line;
        logic        stat_high;
        logic        pend;
    } state_t;

    localparam state_t STATE_CLEAR = '{
        mode:       MODE_HBLANK,
        line_dots:  9'd0,
        frame_dots: 17'd0,
        line:       8'd0,
        stat_high:  1'b0,
        pend:       1'b0
    };

    typedef struct packed {
        logic [3:0] stat_enables;
        logic [7:0] line_compare;
    } cfg_t;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] line;
        logic [8:0] line_dot;
        logic       sprite_fetch;
        logic [5:0] sprite_index;
        logic       scanline_start;
        logic       vblank_irq;
        logic       stat_irq;
        logic       frame_done;
        logic       hblank_start;
        logic       vram_blocked;
        logic       oam_blocked;
    } result_t;

    // Level of the OR of the enabled status sources for a given mode and line.
    function automatic logic stat_now(input mode_t m, input logic [7:0] ln, input cfg_t c);
        logic lvl;
        lvl = (c.stat_enables[3] && (ln == c.line_compare))
            || ((m == MODE_HBLANK) && c.stat_enables[0])
            || ((m == MODE_VBLANK) && c.stat_enables[1])
            || ((m == MODE_SCAN) && c.stat_enables[2]);
        return lvl;
    endfunction

endpackage

`default_nettype wire

// File: hdl/lcdt_in_if.sv
`default_nettype none

interface lcdt_in_if;
    logic valid;
    logic ready;
    logic line_end;

    modport source (output valid, output line_end, input ready);
    modport sink (input valid, input line_end, output ready);
endinterface

`default_nettype wire

// File: hdl/lcdt_out_if.sv
`default_nettype none

interface lcdt_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [7:0] line;
    logic [8:0] line_dot;
    logic       sprite_fetch;
    logic [5:0] sprite_index;
    logic       scanline_start;
    logic       vblank_irq;
    logic       stat_irq;
    logic       frame_done;
    logic       hblank_start;
    logic       vram_blocked;
    logic       oam_blocked;

    modport source (
        output valid, output mode, output line, output line_dot, output sprite_fetch,
        output sprite_index, output scanline_start, output vblank_irq, output stat_irq,
        output frame_done, output hblank_start, output vram_blocked, output oam_blocked,
        input ready
    );
    modport sink (
        input valid, input mode, input line, input line_dot, input sprite_fetch,
        input sprite_index, input scanline_start, input vblank_irq, input stat_irq,
        input frame_done, input hblank_start, input vram_blocked, input oam_blocked,
        output ready
    );
endinterface

`default_nettype wire

// File: hdl/lcdt_step.sv
`default_nettype none

module lcdt_step #(
    parameter int LINE_DOTS     = 456,
    parameter int SCAN_DOTS     = 80,
    parameter int VISIBLE_LINES = 144,
    parameter int TOTAL_LINES   = 154
) (
    input  lcdt_pkg::state_t  st,
    input  lcdt_pkg::cfg_t    cfg,
    input  logic              line_end,
    output lcdt_pkg::state_t  nxt,
    output lcdt_pkg::result_t res
);
    import lcdt_pkg::*;

    localparam logic [8:0]  LINE_END  = 9'(LINE_DOTS);
    localparam logic [8:0]  SCAN_END  = 9'(SCAN_DOTS);
    localparam logic [16:0] VIS_END   = 17'(VISIBLE_LINES * LINE_DOTS);
    localparam logic [16:0] FRAME_END = 17'(TOTAL_LINES * LINE_DOTS);

    logic [8:0]  ld_inc;
    logic [16:0] fd_inc;
    logic        fetch;

    assign ld_inc = st.line_dots + 9'd1;
    assign fd_inc = st.frame_dots + 17'd1;
    assign fetch  = (st.mode == MODE_SCAN) && !st.line_dots[0]
                    && (st.line_dots[8:1] < OAM_ENTRIES);

    // The status sources are sampled after every mode or line change in a dot, in order.
    // Each sample is compared with the one before it, and any rising edge raises the pulse.
    always_comb
    begin
        logic prev;
        logic lvl;
        logic sirq;
        logic sstart;
        logic hstart;
        logic vbl;

        nxt            = st;
        nxt.pend       = 1'b0;
        nxt.line_dots  = ld_inc;
        nxt.frame_dots = fd_inc;
        prev           = st.stat_high;
        lvl            = 1'b0;
        sirq           = st.pend;
        sstart         = 1'b0;
        hstart         = 1'b0;
        vbl            = 1'b0;

        case (st.mode)
            MODE_SCAN:
            begin
                if (ld_inc >= SCAN_END)
                begin
                    nxt.mode = MODE_XFER;
                    lvl      = stat_now(MODE_XFER, nxt.line, cfg);
                    sirq     = sirq | (lvl & ~prev);
                    prev     = lvl;
                    sstart   = 1'b1;
                end
            end
            MODE_XFER:
            begin
                if (line_end)
                begin
                    nxt.mode = MODE_HBLANK;
                    lvl      = stat_now(MODE_HBLANK, nxt.line, cfg);
                    sirq     = sirq | (lvl & ~prev);
                    prev     = lvl;
                    hstart   = 1'b1;
                end
            end
            MODE_HBLANK:
            begin
                if (ld_inc >= LINE_END)
                begin
                    nxt.mode      = MODE_SCAN;
                    lvl           = stat_now(MODE_SCAN, nxt.line, cfg);
                    sirq          = sirq | (lvl & ~prev);
                    prev          = lvl;
                    nxt.line_dots = 9'd0;
                    nxt.line      = nxt.line + 8'd1;
                    lvl           = stat_now(MODE_SCAN, nxt.line, cfg);
                    sirq          = sirq | (lvl & ~prev);
                    prev          = lvl;
                end
                if (fd_inc >= VIS_END)
                begin
                    nxt.mode = MODE_VBLANK;
                    lvl      = stat_now(MODE_VBLANK, nxt.line, cfg);
                    sirq     = sirq | (lvl & ~prev);
                    prev     = lvl;
                    vbl      = 1'b1;
                end
            end
            default:
            begin
                if (ld_inc >= LINE_END)
                begin
                    nxt.line_dots = 9'd0;
                    nxt.line      = nxt.line + 8'd1;
                    lvl           = stat_now(MODE_VBLANK, nxt.line, cfg);
                    sirq          = sirq | (lvl & ~prev);
                    prev          = lvl;
                end
                // The last line reads back as line zero a few dots into it.
                if ((nxt.line == QUIRK_LINE) && (nxt.line_dots == QUIRK_DOT))
                begin
                    nxt.line = 8'd0;
                    lvl      = stat_now(MODE_VBLANK, nxt.line, cfg);
                    sirq     = sirq | (lvl & ~prev);
                    prev     = lvl;
                end
                if (fd_inc >= FRAME_END)
                begin
                    nxt.mode       = MODE_SCAN;
                    lvl            = stat_now(MODE_SCAN, nxt.line, cfg);
                    sirq           = sirq | (lvl & ~prev);
                    prev           = lvl;
                    nxt.frame_dots = 17'd0;
                    nxt.line       = 8'd0;
                end
            end
        endcase

        nxt.stat_high = prev;

        res.mode           = nxt.mode;
        res.line           = nxt.line;
        res.line_dot       = nxt.line_dots;
        res.sprite_fetch   = fetch;
        res.sprite_index   = fetch ? st.line_dots[6:1] : 6'd0;
        res.scanline_start = sstart;
        res.vblank_irq     = vbl;
        res.stat_irq       = sirq;
        res.frame_done     = vbl;
        res.hblank_start   = hstart;
        res.vram_blocked   = (nxt.mode == MODE_XFER);
        res.oam_blocked    = (nxt.mode == MODE_XFER) || (nxt.mode == MODE_SCAN);
    end

endmodule

`default_nettype wire

// File: hdl/lcd_dot_timing_mode_controller_core.sv
// Channel   Role   Payload                                        Transfer when
// dot       sink   line_end                                       dot.valid && dot.ready
// result    source mode, line, line_dot, sprite and irq fields    result.valid && result.ready
// cfg       write  cfg_index, cfg_data                            cfg_we
//
// One dot per clock unless stalled: a dot is taken in the cycle it arrives while dot.ready is
// high, and its result is registered for the next cycle, so the sustained rate is one dot per
// cycle while result.ready is high. The single result register holds each result; dot.ready
// stays high while the result register is empty or is being emptied in the same cycle.
// Reset clears the counters, the mode and the configuration; the display starts off.
`default_nettype none

module lcd_dot_timing_mode_controller_core #(
    parameter int LINE_DOTS     = 456,
    parameter int SCAN_DOTS     = 80,
    parameter int VISIBLE_LINES = 144,
    parameter int TOTAL_LINES   = 154
) (
    input  logic                                clk,
    input  logic                                rst_n,
    lcdt_in_if.sink                             dot,
    lcdt_out_if.source                          result,
    input  logic                                cfg_we,
    input  logic [lcdt_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [lcdt_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import lcdt_pkg::*;

    logic    lcd_enable_reg;
    logic    lcd_enable_next;
    cfg_t    cfg_reg;
    cfg_t    cfg_next;
    state_t  st_reg;
    state_t  st_next;
    state_t  step_nxt;
    result_t step_res;
    result_t res_reg;
    logic    out_valid_reg;
    logic    accept;

    lcdt_step #(
        .LINE_DOTS     (LINE_DOTS),
        .SCAN_DOTS     (SCAN_DOTS),
        .VISIBLE_LINES (VISIBLE_LINES),
        .TOTAL_LINES   (TOTAL_LINES)
    ) u_step (
        .st       (st_reg),
        .cfg      (cfg_reg),
        .line_end (dot.line_end),
        .nxt      (step_nxt),
        .res      (step_res)
    );

    assign dot.ready = !out_valid_reg || result.ready;
    assign accept    = dot.valid && dot.ready;

    always_comb
    begin
        logic lvl;

        lcd_enable_next = lcd_enable_reg;
        cfg_next        = cfg_reg;
        st_next         = st_reg;
        lvl             = 1'b0;

        if (cfg_we)
        begin
            case (cfg_index)
                REG_LCD_ENABLE:
                begin
                    lcd_enable_next = cfg_data[0];
                    if (!cfg_data[0])
                    begin
                        st_next = STATE_CLEAR;
                    end
                    else if (!lcd_enable_reg)
                    begin
                        // Switching on enters OAM scan; an edge found here is
                        // reported with the next dot.
                        st_next.mode      = MODE_SCAN;
                        lvl               = stat_now(MODE_SCAN, st_reg.line, cfg_reg);
                        st_next.stat_high = lvl;
                        st_next.pend      = st_reg.pend | (lvl & ~st_reg.stat_high);
                    end
                end
                REG_STAT_ENABLES: cfg_next.stat_enables = cfg_data[3:0];
                REG_LINE_COMPARE: cfg_next.line_compare = cfg_data[7:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
        else if (accept && lcd_enable_reg)
        begin
            st_next = step_nxt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lcd_enable_reg <= 1'b0;
            cfg_reg        <= '0;
            st_reg         <= STATE_CLEAR;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            lcd_enable_reg <= lcd_enable_next;
            cfg_reg        <= cfg_next;
            st_reg         <= st_next;
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // A disabled display reports an all-zero result for every dot.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= lcd_enable_reg ? step_res : '0;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.mode           = res_reg.mode;
    assign result.line           = res_reg.line;
    assign result.line_dot       = res_reg.line_dot;
    assign result.sprite_fetch   = res_reg.sprite_fetch;
    assign result.sprite_index   = res_reg.sprite_index;
    assign result.scanline_start = res_reg.scanline_start;
    assign result.vblank_irq     = res_reg.vblank_irq;
    assign result.stat_irq       = res_reg.stat_irq;
    assign result.frame_done     = res_reg.frame_done;
    assign result.hblank_start   = res_reg.hblank_start;
    assign result.vram_blocked   = res_reg.vram_blocked;
    assign result.oam_blocked    = res_reg.oam_blocked;

endmodule

`default_nettype wire
